// ----- rtl/core/reorder_buffer_in_order_retire_defines.svh -----
// Assertion macros shared by the reorder buffer checker.
// No dependencies; include by bare file name.
`ifndef REORDER_BUFFER_IN_ORDER_RETIRE_DEFINES_SVH
`define REORDER_BUFFER_IN_ORDER_RETIRE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ROBIR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ROBIR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/robir_pkg.sv -----
// Package for the in-order reorder buffer: field widths, codes, word types.
// No dependencies.
package robir_pkg;

  localparam int OP_W             = 2;
  localparam int KIND_W           = 2;
  localparam int TAG_W            = 16;
  localparam int SLOT_W           = 6;
  localparam int ROB_SIZE_W       = 7;
  localparam int RETIRE_WIDTH_W   = 4;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 7;

  localparam int ROB_DEPTH_DEF    = 64;
  localparam int RETIRE_MAX_DEF   = 8;
  localparam int TAG_BITS_DEF     = 16;

  localparam int ROB_SIZE_RST     = 64;
  localparam int RETIRE_WIDTH_RST = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_RETIRE   = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_REFUSED = 2'd1,
    KIND_RETIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROB_SIZE     = 1'b0,
    CFG_RETIRE_WIDTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] entry_index;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  retired_tag;
    logic              last;
    logic              is_empty;
  } rsp_t;

endpackage

// ----- rtl/core/robir_adv.sv -----
// Shared pointer advance unit: increment with wrap at the live buffer size.
// Depends on nothing; used by the reorder buffer sequencer.
module robir_adv #(
  parameter int PTR_W = 6,
  parameter int CNT_W = 7
) (
  input  logic [PTR_W-1:0] ptr,
  input  logic [CNT_W-1:0] size,
  output logic [PTR_W-1:0] nxt
);

  logic [CNT_W-1:0] inc;

  assign inc = CNT_W'(ptr) + CNT_W'(1);
  // wrap to slot zero at or past the live size
  assign nxt = (inc >= size) ? '0 : PTR_W'(inc);

endmodule

// ----- rtl/core/robir_tag_ram.sv -----
// Tag store of the reorder buffer: one write port, one registered read port.
// No dependencies.
module robir_tag_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/reorder_buffer_in_order_retire.sv -----
// Circular reorder buffer with in-order retirement; top level.
// Depends on robir_pkg, robir_adv and robir_tag_ram.
//
// A command word is taken on a clock edge with start high and busy low. Allocate,
// complete and unknown commands keep busy low, and the single result word is
// strobed in the next cycle, so a new command may follow at once.
// A retire command first walks the head entries to count how many retire (one
// entry per cycle, plus a scan step to stop), then sends one result word per
// retired entry, one per cycle, as the tag store has one read port; a retire
// with nothing to retire answers with one word from the scan state. Busy is
// high throughout. Result words are strobed for exactly one cycle and cannot be
// held off; every word carries the empty flag of the buffer after the command.
// Tags are stored in a memory without clearing; done marks reset at once.
module reorder_buffer_in_order_retire #(
  parameter int ROB_DEPTH  = robir_pkg::ROB_DEPTH_DEF,
  parameter int RETIRE_MAX = robir_pkg::RETIRE_MAX_DEF,
  parameter int TAG_BITS   = robir_pkg::TAG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  robir_pkg::cmd_t                     cmd,
  output robir_pkg::rsp_t                     rsp,
  output logic                                rsp_strobe,
  input  logic                                cfg_we,
  input  logic [robir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [robir_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PTR_W  = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
  localparam int CNT_W  = $clog2(ROB_DEPTH + 1);
  localparam int RW_W   = $clog2(RETIRE_MAX + 1);
  localparam int SZ_W   = (CNT_W > robir_pkg::ROB_SIZE_W) ? CNT_W : robir_pkg::ROB_SIZE_W;
  localparam int WX_W   = (RW_W > robir_pkg::RETIRE_WIDTH_W) ? RW_W
                                                              : robir_pkg::RETIRE_WIDTH_W;
  localparam int IX_W   = (CNT_W > robir_pkg::SLOT_W) ? CNT_W : robir_pkg::SLOT_W;
  localparam int SLOT_W = robir_pkg::SLOT_W;
  localparam int TAG_W  = robir_pkg::TAG_W;
  localparam int SIZE_RST  = (ROB_DEPTH < robir_pkg::ROB_SIZE_RST) ? ROB_DEPTH
                                                                   : robir_pkg::ROB_SIZE_RST;
  localparam int WIDTH_RST = (RETIRE_MAX < robir_pkg::RETIRE_WIDTH_RST) ? RETIRE_MAX
                                                                       : robir_pkg::RETIRE_WIDTH_RST;

  robir_pkg::state_t state, state_next;

  logic [PTR_W-1:0]     head_ptr, head_ptr_next;
  logic [PTR_W-1:0]     tail_ptr, tail_ptr_next;
  logic [CNT_W-1:0]     occupancy, occupancy_next;
  logic [CNT_W-1:0]     size_eff, size_eff_next;
  logic [RW_W-1:0]      width_eff, width_eff_next;
  logic [ROB_DEPTH-1:0] done, done_next;
  logic [PTR_W-1:0]     scan_ptr, scan_ptr_next;
  logic [CNT_W-1:0]     scan_occ, scan_occ_next;
  logic [RW_W-1:0]      scan_cnt, scan_cnt_next;
  logic [RW_W-1:0]      left, left_next;
  logic                 final_empty, final_empty_next;
  robir_pkg::rsp_t      rsp_next;
  logic                 rsp_strobe_next;

  logic [PTR_W-1:0]     adv_in, adv_out;
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_raddr;
  logic [TAG_BITS-1:0]  ram_rdata;

  logic [SZ_W-1:0]      rs_ext;
  logic [WX_W-1:0]      rw_ext;
  logic [CNT_W-1:0]     size_wr;
  logic [RW_W-1:0]      width_wr;
  logic [IX_W-1:0]      idx_ext;
  logic                 take;

  robir_adv #(
    .PTR_W (PTR_W),
    .CNT_W (CNT_W)
  ) u_adv (
    .ptr  (adv_in),
    .size (size_eff),
    .nxt  (adv_out)
  );

  robir_tag_ram #(
    .DEPTH (ROB_DEPTH),
    .WIDTH (TAG_BITS),
    .AW    (PTR_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_ptr),
    .wdata (TAG_BITS'(cmd.tag)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clamp configuration values into their working ranges
  assign rs_ext   = SZ_W'(cfg_data);
  assign rw_ext   = WX_W'(cfg_data[robir_pkg::RETIRE_WIDTH_W-1:0]);
  assign size_wr  = (rs_ext == '0) ? CNT_W'(1) :
                    (rs_ext > SZ_W'(ROB_DEPTH)) ? CNT_W'(ROB_DEPTH) : CNT_W'(rs_ext);
  assign width_wr = (rw_ext == '0) ? RW_W'(1) :
                    (rw_ext > WX_W'(RETIRE_MAX)) ? RW_W'(RETIRE_MAX) : RW_W'(rw_ext);

  assign idx_ext  = IX_W'(cmd.entry_index);
  assign take     = (scan_cnt < width_eff) && (scan_occ != '0) && done[scan_ptr];
  assign busy     = (state != robir_pkg::ST_IDLE);

  always_comb begin
    state_next       = state;
    head_ptr_next    = head_ptr;
    tail_ptr_next    = tail_ptr;
    occupancy_next   = occupancy;
    size_eff_next    = size_eff;
    width_eff_next   = width_eff;
    done_next        = done;
    scan_ptr_next    = scan_ptr;
    scan_occ_next    = scan_occ;
    scan_cnt_next    = scan_cnt;
    left_next        = left;
    final_empty_next = final_empty;
    rsp_next         = '0;
    rsp_next.last    = 1'b1;
    rsp_strobe_next  = 1'b0;
    ram_we           = 1'b0;
    ram_raddr        = head_ptr;
    adv_in           = tail_ptr;

    if (cfg_we) begin
      case (cfg_index)
        robir_pkg::CFG_ROB_SIZE:     size_eff_next  = size_wr;
        robir_pkg::CFG_RETIRE_WIDTH: width_eff_next = width_wr;
        default: ;
      endcase
    end

    case (state)
      robir_pkg::ST_IDLE: begin
        adv_in = tail_ptr;
        if (start) begin
          rsp_strobe_next = 1'b1;
          case (cmd.operation)
            robir_pkg::OP_ALLOC: begin
              if (occupancy >= size_eff) begin
                rsp_next.kind = robir_pkg::KIND_REFUSED;
              end else begin
                ram_we                  = 1'b1;
                done_next[tail_ptr]     = 1'b0;
                tail_ptr_next           = adv_out;
                occupancy_next          = occupancy + CNT_W'(1);
                rsp_next.kind           = robir_pkg::KIND_ALLOC;
                rsp_next.slot           = SLOT_W'(tail_ptr);
              end
            end
            robir_pkg::OP_COMPLETE: begin
              // out-of-range slots are acknowledged but left alone
              if (idx_ext < IX_W'(size_eff)) begin
                done_next[idx_ext[PTR_W-1:0]] = 1'b1;
              end
              rsp_next.kind = robir_pkg::KIND_NONE;
              rsp_next.slot = cmd.entry_index;
            end
            robir_pkg::OP_RETIRE: begin
              rsp_strobe_next = 1'b0;
              scan_ptr_next   = head_ptr;
              scan_occ_next   = occupancy;
              scan_cnt_next   = '0;
              state_next      = robir_pkg::ST_SCAN;
            end
            default: begin
              rsp_next.kind = robir_pkg::KIND_NONE;
            end
          endcase
          rsp_next.is_empty = (occupancy_next == '0);
        end
      end

      robir_pkg::ST_SCAN: begin
        adv_in = scan_ptr;
        if (take) begin
          scan_cnt_next = scan_cnt + RW_W'(1);
          scan_occ_next = scan_occ - CNT_W'(1);
          scan_ptr_next = adv_out;
        end else if (scan_cnt == '0) begin
          rsp_next.kind     = robir_pkg::KIND_NONE;
          rsp_next.is_empty = (occupancy == '0);
          rsp_strobe_next   = 1'b1;
          state_next        = robir_pkg::ST_IDLE;
        end else begin
          // head tag read is issued here, data lands for the first emit cycle
          left_next        = scan_cnt;
          final_empty_next = (scan_occ == '0);
          state_next       = robir_pkg::ST_EMIT;
        end
      end

      robir_pkg::ST_EMIT: begin
        adv_in               = head_ptr;
        rsp_next.kind        = robir_pkg::KIND_RETIRED;
        rsp_next.slot        = SLOT_W'(head_ptr);
        rsp_next.retired_tag = TAG_W'(ram_rdata);
        rsp_next.last        = (left == RW_W'(1));
        rsp_next.is_empty    = final_empty;
        rsp_strobe_next      = 1'b1;
        done_next[head_ptr]  = 1'b0;
        head_ptr_next        = adv_out;
        occupancy_next       = occupancy - CNT_W'(1);
        left_next            = left - RW_W'(1);
        ram_raddr            = adv_out;
        if (left == RW_W'(1)) begin
          state_next = robir_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = robir_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= robir_pkg::ST_IDLE;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      occupancy  <= '0;
      size_eff   <= CNT_W'(SIZE_RST);
      width_eff  <= RW_W'(WIDTH_RST);
      done       <= '0;
      scan_ptr   <= '0;
      scan_occ   <= '0;
      scan_cnt   <= '0;
      left       <= '0;
      rsp_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      head_ptr   <= head_ptr_next;
      tail_ptr   <= tail_ptr_next;
      occupancy  <= occupancy_next;
      size_eff   <= size_eff_next;
      width_eff  <= width_eff_next;
      done       <= done_next;
      scan_ptr   <= scan_ptr_next;
      scan_occ   <= scan_occ_next;
      scan_cnt   <= scan_cnt_next;
      left       <= left_next;
      rsp_strobe <= rsp_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    final_empty <= final_empty_next;
    rsp         <= rsp_next;
  end

endmodule

// ----- rtl/core/robir_checker.sv -----
// Port-level checks for the reorder buffer, bound to the top level.
// Depends on robir_pkg and reorder_buffer_in_order_retire_defines.svh.
`include "reorder_buffer_in_order_retire_defines.svh"

module robir_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input robir_pkg::cmd_t cmd,
  input robir_pkg::rsp_t rsp,
  input logic            rsp_strobe
);

  // allocate, complete and unknown commands answer with one final word in the next cycle
  `ROBIR_ASSERT_NEXT(a_single_word, clk, rst, start && !busy && (cmd.operation != robir_pkg::OP_RETIRE), rsp_strobe && rsp.last, "single-cycle command gave no final word")

  // a retire burst runs without gaps
  `ROBIR_ASSERT_NEXT(a_burst_gapless, clk, rst, rsp_strobe && !rsp.last, rsp_strobe && (rsp.kind == robir_pkg::KIND_RETIRED), "retire burst broken")

  // a non-final word only appears while a retire is in progress
  `ROBIR_ASSERT_NOW(a_mid_busy, clk, rst, rsp_strobe && !rsp.last, busy && (rsp.kind == robir_pkg::KIND_RETIRED), "non-final word outside a retire")

  // after a successful allocate the buffer cannot be empty
  `ROBIR_ASSERT_NOW(a_alloc_not_empty, clk, rst, rsp_strobe && (rsp.kind == robir_pkg::KIND_ALLOC), !rsp.is_empty, "allocate reported an empty buffer")

endmodule

bind reorder_buffer_in_order_retire robir_checker u_robir_checker (.*);
